FILE: hw/rtl/spectrum_peak_fall_bar_meter_defines.svh
// ----------------------------------------------------------------------------
// spectrum peak fall bar meter assertion macros
// Shared concurrent assertion helpers, empty for synthesis.
// ----------------------------------------------------------------------------
`ifndef SPECTRUM_PEAK_FALL_BAR_METER_DEFINES_SVH
`define SPECTRUM_PEAK_FALL_BAR_METER_DEFINES_SVH

`ifndef SYNTHESIS
`define SPFB_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("spfb assertion failed");
`define SPFB_NEVER(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("spfb forbidden condition");
`else
`define SPFB_ASSERT(lbl, clk, rst, prop)
`define SPFB_NEVER(lbl, clk, rst, expr)
`endif

`endif

FILE: hw/rtl/spfb_pkg.sv
// ----------------------------------------------------------------------------
// spfb package
// Types and constants of the spectrum peak fall bar meter.
// ----------------------------------------------------------------------------
`default_nettype none

package spfb_pkg;

   localparam int NUM_BINS     = 128;
   localparam int BIN_IDX_W    = $clog2(NUM_BINS);

   localparam int LEVEL_W      = 16;
   localparam int BAR_W        = 7;
   localparam int PIX_W        = 12;
   localparam int CNT_W        = 8;
   localparam int FILL_W       = 8;

   localparam int REQ_TDATA_W  = 16;
   localparam int RSP_TDATA_W  = 24;

   localparam int CSR_IDX_W    = 3;
   localparam int CSR_DATA_W   = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_BAR_COUNT     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BINS_PER_BAR  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_GRAVITY_ON    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_FALL_STEP     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_COLUMN_HEIGHT = 3'd4;

   localparam logic [CNT_W-1:0]   MAX_BARS          = 8'd128;
   localparam logic [CNT_W-1:0]   RST_BAR_COUNT     = 8'd6;
   localparam logic [CNT_W-1:0]   RST_BINS_PER_BAR  = 8'd1;
   localparam logic [LEVEL_W-1:0] RST_FALL_STEP     = 16'd3277;
   localparam logic [PIX_W-1:0]   RST_COLUMN_HEIGHT = 12'd32;

   typedef struct packed {
      logic [CNT_W-1:0]   bar_count;
      logic [CNT_W-1:0]   bins_per_bar;
      logic               gravity_on;
      logic [LEVEL_W-1:0] fall_step;
      logic [PIX_W-1:0]   column_height;
   } cfg_type;

   typedef struct packed {
      logic               valid;
      logic [LEVEL_W-1:0] level;
      logic               frame_end;
   } hold_item_type;

endpackage

`default_nettype wire

FILE: hw/rtl/spfb_cfg.sv
// ----------------------------------------------------------------------------
// spfb configuration registers
// Holds the meter settings; a write to a known register restarts the frame.
// ----------------------------------------------------------------------------
`default_nettype none

module spfb_cfg (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             csr_we,
   input  wire logic [spfb_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [spfb_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output spfb_pkg::cfg_type                     cfg,
   output logic                                  restart
);
   import spfb_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;
   logic    hit;

   always_comb begin
      cfg_in = cfg_ff;
      hit    = 1'b1;
      case (csr_index)
         CSR_BAR_COUNT:     cfg_in.bar_count     = csr_wdata[CNT_W-1:0];
         CSR_BINS_PER_BAR:  cfg_in.bins_per_bar  = csr_wdata[CNT_W-1:0];
         CSR_GRAVITY_ON:    cfg_in.gravity_on    = csr_wdata[0];
         CSR_FALL_STEP:     cfg_in.fall_step     = csr_wdata[LEVEL_W-1:0];
         CSR_COLUMN_HEIGHT: cfg_in.column_height = csr_wdata[PIX_W-1:0];
         default:           hit                  = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.bar_count     <= RST_BAR_COUNT;
         cfg_ff.bins_per_bar  <= RST_BINS_PER_BAR;
         cfg_ff.gravity_on    <= 1'b0;
         cfg_ff.fall_step     <= RST_FALL_STEP;
         cfg_ff.column_height <= RST_COLUMN_HEIGHT;
      end else if (csr_we && hit) begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg     = cfg_ff;
   assign restart = csr_we && hit;

endmodule

`default_nettype wire

FILE: hw/rtl/spfb_peak_hold.sv
// ----------------------------------------------------------------------------
// spfb peak hold
// Input register, held level memory and falling peak update per bin.
// ----------------------------------------------------------------------------
`default_nettype none

module spfb_peak_hold (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire spfb_pkg::cfg_type                 cfg,
   input  wire logic                              restart,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   input  wire logic [spfb_pkg::REQ_TDATA_W-1:0]  req_tdata,
   input  wire logic                              req_tlast,
   input  wire logic                              fire,
   output spfb_pkg::hold_item_type                item
);
   import spfb_pkg::*;

   logic [LEVEL_W-1:0]   mem [NUM_BINS];

   logic                 s1_valid_ff;
   logic [LEVEL_W-1:0]   s1_level_ff;
   logic                 s1_last_ff;
   logic [BIN_IDX_W-1:0] s1_pos_ff;
   logic [LEVEL_W-1:0]   rd_data_ff;
   logic                 fwd_ff;
   logic                 fwd_in;
   logic [LEVEL_W-1:0]   fwd_data_ff;
   logic                 history_ff;
   logic [BIN_IDX_W-1:0] pos_ff;
   logic [BIN_IDX_W-1:0] pos_in;

   logic                 accept;
   logic [LEVEL_W-1:0]   held;
   logic [LEVEL_W-1:0]   fallen;
   logic [LEVEL_W-1:0]   level_new;

   assign req_tready = !s1_valid_ff || fire;
   assign accept     = req_tvalid && req_tready;

   // bin just written by the outgoing item is read again by the incoming one
   assign fwd_in = fire && accept && (s1_pos_ff == pos_ff);
   assign held   = fwd_ff ? fwd_data_ff : rd_data_ff;

   always_comb begin
      fallen    = (held > cfg.fall_step) ? (held - cfg.fall_step) : '0;
      level_new = s1_level_ff;
      if (cfg.gravity_on && history_ff && (s1_level_ff < held)) begin
         level_new = (fallen < s1_level_ff) ? s1_level_ff : fallen;
      end
   end

   always_comb begin
      if (req_tlast || (pos_ff == BIN_IDX_W'(NUM_BINS - 1))) begin
         pos_in = '0;
      end else begin
         pos_in = pos_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         mem[s1_pos_ff] <= level_new;
      end
      if (accept) begin
         rd_data_ff <= mem[pos_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_level_ff <= req_tdata[LEVEL_W-1:0];
         s1_last_ff  <= req_tlast;
         s1_pos_ff   <= pos_ff;
         fwd_data_ff <= level_new;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         fwd_ff      <= 1'b0;
         history_ff  <= 1'b0;
         pos_ff      <= '0;
      end else begin
         if (accept) begin
            s1_valid_ff <= 1'b1;
            fwd_ff      <= fwd_in;
         end else if (fire) begin
            s1_valid_ff <= 1'b0;
         end
         if (restart) begin
            history_ff <= 1'b0;
            pos_ff     <= '0;
         end else begin
            if (fire && s1_last_ff) begin
               history_ff <= 1'b1;
            end
            if (accept) begin
               pos_ff <= pos_in;
            end
         end
      end
   end

   assign item.valid     = s1_valid_ff;
   assign item.level     = level_new;
   assign item.frame_end = s1_last_ff;

endmodule

`default_nettype wire

FILE: hw/rtl/spfb_bar_merge.sv
// ----------------------------------------------------------------------------
// spfb bar merge
// Group maximum, bar counting, lit pixel scaling and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "spectrum_peak_fall_bar_meter_defines.svh"

module spfb_bar_merge (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire spfb_pkg::cfg_type                 cfg,
   input  wire logic                              restart,
   input  wire spfb_pkg::hold_item_type           item,
   output logic                                   fire,
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   output logic [spfb_pkg::RSP_TDATA_W-1:0]       rsp_tdata,
   output logic                                   rsp_tlast
);
   import spfb_pkg::*;

   logic [LEVEL_W-1:0] group_peak_ff;
   logic [FILL_W-1:0]  fill_ff;
   logic [CNT_W-1:0]   bar_pos_ff;

   logic               rsp_valid_ff;
   logic [BAR_W-1:0]   rsp_bar_ff;
   logic [PIX_W-1:0]   rsp_pix_ff;
   logic               rsp_last_ff;

   logic [CNT_W-1:0]   bars;
   logic [CNT_W-1:0]   per;
   logic               active;
   logic [LEVEL_W-1:0] peak_new;
   logic [FILL_W:0]    fill_inc;
   logic               done;
   logic               out_free;
   logic [27:0]        prod;
   logic [28:0]        rounded;
   logic [PIX_W:0]     pix_raw;
   logic [PIX_W-1:0]   pix;
   logic               last_bar;

   assign bars     = (cfg.bar_count > MAX_BARS) ? MAX_BARS : cfg.bar_count;
   assign per      = (cfg.bins_per_bar == '0) ? CNT_W'(1) : cfg.bins_per_bar;
   assign active   = bar_pos_ff < bars;
   assign peak_new = (item.level > group_peak_ff) ? item.level : group_peak_ff;
   assign fill_inc = {1'b0, fill_ff} + 1'b1;
   assign done     = active && (fill_inc >= {1'b0, per});
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign fire     = item.valid && (!done || out_free);

   // ceil of height times level over 2^16, capped at height
   assign prod     = cfg.column_height * peak_new;
   assign rounded  = {1'b0, prod} + 29'(16'hFFFF);
   assign pix_raw  = rounded[28:16];
   assign pix      = (pix_raw > {1'b0, cfg.column_height}) ? cfg.column_height
                                                           : pix_raw[PIX_W-1:0];
   assign last_bar = ({1'b0, bar_pos_ff} + 1'b1 == {1'b0, bars}) || item.frame_end;

   always_ff @(posedge clock) begin
      if (fire && done) begin
         rsp_bar_ff  <= bar_pos_ff[BAR_W-1:0];
         rsp_pix_ff  <= pix;
         rsp_last_ff <= last_bar;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         group_peak_ff <= '0;
         fill_ff       <= '0;
         bar_pos_ff    <= '0;
      end else begin
         if (fire && done) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (restart || (fire && item.frame_end)) begin
            group_peak_ff <= '0;
            fill_ff       <= '0;
            bar_pos_ff    <= '0;
         end else if (fire && active) begin
            if (done) begin
               group_peak_ff <= '0;
               fill_ff       <= '0;
               bar_pos_ff    <= bar_pos_ff + 1'b1;
            end else begin
               group_peak_ff <= peak_new;
               fill_ff       <= fill_inc[FILL_W-1:0];
            end
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_TDATA_W - BAR_W - PIX_W){1'b0}}, rsp_pix_ff, rsp_bar_ff};
   assign rsp_tlast  = rsp_last_ff;

   `SPFB_NEVER(a_bar_pos_range, clock, reset, bar_pos_ff > MAX_BARS)
   `SPFB_NEVER(a_fill_range, clock, reset, fill_inc > {1'b0, per})
   `SPFB_ASSERT(a_stall_keeps_item, clock, reset, item.valid && !fire |=> item.valid)
   `SPFB_ASSERT(a_frame_restart, clock, reset, fire && item.frame_end |=> !(|{fill_ff, bar_pos_ff}))

endmodule

`default_nettype wire

FILE: hw/rtl/spectrum_peak_fall_bar_meter.sv
// ----------------------------------------------------------------------------
// spectrum peak fall bar meter
// Falling peak hold per spectrum bin, group maximum per bar, lit pixel count.
// ----------------------------------------------------------------------------
// channel   direction  tdata fields (low bit up)            tuser/tlast
// req_      in         bin_level[15:0]                      tlast = frame_end
// rsp_      out        bar_number[6:0], lit_pixels[18:7]    tlast = last_bar
// csr_      in         write enable, index 0..4, data       -
//
// one bin transfer per cycle unless a stalled result holds it; a bar result leaves via the input and result registers
// the held level memory (128 x 16) has one read port and one write port,
// a same bin read after write is forwarded from the update logic
// held levels are not cleared by reset; counters and the history flag are
// a stalled result holds the update stage, the input register then fills
// ----------------------------------------------------------------------------
`default_nettype none

module spectrum_peak_fall_bar_meter (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   input  wire logic [spfb_pkg::REQ_TDATA_W-1:0]  req_tdata,   // bin_level
   input  wire logic                              req_tlast,
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   output logic [spfb_pkg::RSP_TDATA_W-1:0]       rsp_tdata,   // bar_number, lit_pixels
   output logic                                   rsp_tlast,
   input  wire logic                              csr_we,
   input  wire logic [spfb_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [spfb_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import spfb_pkg::*;

   cfg_type       cfg;
   logic          restart;
   hold_item_type item;
   logic          fire;

   spfb_cfg u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg),
      .restart   (restart)
   );

   spfb_peak_hold u_hold (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .restart    (restart),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .fire       (fire),
      .item       (item)
   );

   spfb_bar_merge u_merge (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .restart    (restart),
      .item       (item),
      .fire       (fire),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

`default_nettype wire

FILE: sim/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// spectrum peak fall bar meter testbench
// Streams spectrum bins through the bar meter and predicts every bar result
// with a cycle-free model of the falling peak hold, the group maximum and the
// lit pixel count. Register settings change between idle phases, and the
// stream and result sides idle and stall at random, with one long result
// hold that fills the block and stalls its input.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
   import spfb_pkg::*;

   localparam int CYCLE_LIMIT   = 200000;
   localparam int SETTLE_CYCLES = 8;
   localparam int EXPECT_DEPTH  = 16;
   localparam int STAGE_DEPTH   = 8;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED_INDEX = 3'd7;

   typedef struct packed {
      logic [BAR_W-1:0] bar_number;
      logic [PIX_W-1:0] lit_pixels;
      logic             last_bar;
   } bar_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;   // bin_level
   logic req_tlast = 1'b0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;        // bar_number, lit_pixels
   logic rsp_tlast;
   logic csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   spectrum_peak_fall_bar_meter dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tlast(rsp_tlast),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // predictor state and register mirror
   int unsigned held_level [NUM_BINS];
   bit          history_loaded;
   int unsigned bin_pos, group_peak, group_fill, bar_pos;
   int unsigned reg_bars, reg_per, reg_gravity, reg_step, reg_height;

   // expected bars in a ring, staged register writes in a list
   bar_type               expected_bars [EXPECT_DEPTH];
   int                    expect_head = 0;
   int                    expect_count = 0;
   logic [CSR_IDX_W-1:0]  reg_idx_q [STAGE_DEPTH];
   logic [CSR_DATA_W-1:0] reg_val_q [STAGE_DEPTH];
   int                    stage_count = 0;

   int send_idle_pct = 0;
   int stall_pct = 0;
   int hold_req = 0;
   int hold_left = 0;
   int errors = 0;
   int bins_sent = 0;
   int bars_checked = 0;
   int reg_writes = 0;
   int cycle_count = 0;

   task automatic restart_frame();
      bin_pos = 0;
      group_peak = 0;
      group_fill = 0;
      bar_pos = 0;
   endtask

   task automatic reset_meter_model();
      reg_bars = RST_BAR_COUNT;
      reg_per = RST_BINS_PER_BAR;
      reg_gravity = 0;
      reg_step = RST_FALL_STEP;
      reg_height = RST_COLUMN_HEIGHT;
      foreach (held_level[i]) held_level[i] = 0;
      history_loaded = 1'b0;
      restart_frame();
   endtask

   task automatic apply_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      case (idx)
         CSR_BAR_COUNT:     reg_bars = val[7:0];
         CSR_BINS_PER_BAR:  reg_per = val[7:0];
         CSR_GRAVITY_ON:    reg_gravity = val[0];
         CSR_FALL_STEP:     reg_step = val;
         CSR_COLUMN_HEIGHT: reg_height = val[11:0];
         default:           return;
      endcase
      history_loaded = 1'b0;
      restart_frame();
   endtask

   function automatic int unsigned active_bars();
      return (reg_bars > 128) ? 128 : reg_bars;
   endfunction

   function automatic int unsigned active_per();
      return (reg_per == 0) ? 1 : reg_per;
   endfunction

   task automatic add_expected(input bar_type r);
      if (expect_count == EXPECT_DEPTH) begin
         errors++;
         $display("%0t: too many bars outstanding", $time);
      end else begin
         expected_bars[(expect_head + expect_count) % EXPECT_DEPTH] = r;
         expect_count++;
      end
   endtask

   task automatic predict_bin(input logic [LEVEL_W-1:0] lvl, input logic fe);
      int unsigned pos, v, fallen, n;
      bar_type r;
      pos = bin_pos % NUM_BINS;
      v = lvl;
      if (reg_gravity != 0 && history_loaded && lvl < held_level[pos]) begin
         fallen = (held_level[pos] > reg_step) ? held_level[pos] - reg_step : 0;
         v = (fallen < lvl) ? lvl : fallen;
      end
      held_level[pos] = v;
      bin_pos = (pos + 1) % NUM_BINS;
      if (bar_pos < active_bars()) begin
         if (v > group_peak) group_peak = v;
         group_fill++;
         if (group_fill >= active_per()) begin
            n = (reg_height * group_peak + 65535) >> 16;
            if (n > reg_height) n = reg_height;
            r.bar_number = bar_pos[BAR_W-1:0];
            r.lit_pixels = n[PIX_W-1:0];
            r.last_bar = (bar_pos + 1 == active_bars()) || fe;
            add_expected(r);
            bar_pos++;
            group_peak = 0;
            group_fill = 0;
         end
      end
      if (fe) begin
         history_loaded = 1'b1;
         restart_frame();
      end
   endtask

   // result side: random stall or a counted long hold
   always @(posedge clock) begin
      if (hold_req != 0) begin
         hold_left = hold_req;
         hold_req = 0;
      end
      if (hold_left != 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= stall_pct);
      end
   end

   always @(posedge clock) begin : check_bars
      bar_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.bar_number = rsp_tdata[BAR_W-1:0];
         got.lit_pixels = rsp_tdata[BAR_W+PIX_W-1:BAR_W];
         got.last_bar = rsp_tlast;
         if (expect_count == 0) begin
            errors++;
            $display("%0t: unexpected bar transfer: actual bar %0d lit %0d last %0d",
                     $time, got.bar_number, got.lit_pixels, got.last_bar);
         end else begin
            want = expected_bars[expect_head];
            expect_head = (expect_head + 1) % EXPECT_DEPTH;
            expect_count--;
            bars_checked++;
            if (got !== want) begin
               errors++;
               $display("%0t: bar mismatch: expected bar %0d lit %0d last %0d, actual bar %0d lit %0d last %0d",
                        $time, want.bar_number, want.lit_pixels, want.last_bar,
                        got.bar_number, got.lit_pixels, got.last_bar);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d bars outstanding", $time, expect_count);
         $display("spectrum_peak_fall_bar_meter test failed");
         $finish;
      end
   end

   task automatic send_bin(input logic [LEVEL_W-1:0] lvl, input logic fe);
      int gap;
      req_tvalid <= 1'b1;
      req_tdata <= lvl;
      req_tlast <= fe;
      do @(posedge clock); while (!req_tready);
      predict_bin(lvl, fe);
      bins_sent++;
      gap = 0;
      while ($urandom_range(99) < send_idle_pct) gap++;
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic settle_meter();
      req_tvalid <= 1'b0;
      while (expect_count != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic stage_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] val);
      reg_idx_q[stage_count] = idx;
      reg_val_q[stage_count] = val;
      stage_count++;
   endtask

   task automatic commit_regs();
      int i;
      settle_meter();
      for (i = 0; i < stage_count; i++) begin
         csr_we <= 1'b1;
         csr_index <= reg_idx_q[i];
         csr_wdata <= reg_val_q[i];
         @(posedge clock);
         apply_reg(reg_idx_q[i], reg_val_q[i]);
         reg_writes++;
      end
      stage_count = 0;
      csr_we <= 1'b0;
   endtask

   task automatic program_meter(input int unsigned bars, input int unsigned per,
                                input int unsigned grav, input int unsigned step,
                                input int unsigned height);
      stage_reg(CSR_BAR_COUNT, CSR_DATA_W'(bars));
      stage_reg(CSR_BINS_PER_BAR, CSR_DATA_W'(per));
      stage_reg(CSR_GRAVITY_ON, CSR_DATA_W'(grav));
      stage_reg(CSR_FALL_STEP, CSR_DATA_W'(step));
      stage_reg(CSR_COLUMN_HEIGHT, CSR_DATA_W'(height));
      commit_regs();
   endtask

   function automatic logic [LEVEL_W-1:0] random_level();
      case ($urandom_range(7))
         0:       return '0;
         1:       return '1;
         2:       return LEVEL_W'($urandom_range(255));
         3:       return LEVEL_W'(16'hFFFF - $urandom_range(255));
         default: return LEVEL_W'($urandom);
      endcase
   endfunction

   // unused register bits get random noise now and then
   function automatic logic [CSR_DATA_W-1:0] with_noise(input int unsigned val,
                                                        input logic [CSR_DATA_W-1:0] mask);
      logic [CSR_DATA_W-1:0] noise;
      noise = ($urandom_range(3) == 0) ? CSR_DATA_W'($urandom) : '0;
      return (CSR_DATA_W'(val) & mask) | (noise & ~mask);
   endfunction

   task automatic stage_random_config();
      int unsigned bars, per, step, height;
      case ($urandom_range(9))
         0:       bars = 0;
         1:       bars = 128;
         2:       bars = $urandom_range(129, 255);
         3:       bars = $urandom_range(13, 40);
         default: bars = $urandom_range(1, 12);
      endcase
      case ($urandom_range(7))
         0:       per = 0;
         1:       per = (bars <= 2) ? $urandom_range(64, 128) : 1;
         2:       per = (bars <= 8) ? $urandom_range(129, 255) % 8 + 1 : 2;
         default: per = (bars > 12) ? $urandom_range(1, 2) : $urandom_range(1, 6);
      endcase
      case ($urandom_range(4))
         0:       step = 0;
         1:       step = 16'hFFFF;
         2:       step = $urandom;
         default: step = $urandom_range(500, 8000);
      endcase
      case ($urandom_range(5))
         0:       height = 0;
         1:       height = 1;
         2:       height = 12'hFFF;
         3:       height = 32;
         default: height = $urandom_range(4095);
      endcase
      stage_reg(CSR_BAR_COUNT, with_noise(bars, 16'h00FF));
      stage_reg(CSR_BINS_PER_BAR, with_noise(per, 16'h00FF));
      stage_reg(CSR_GRAVITY_ON, with_noise($urandom_range(9) < 7, 16'h0001));
      stage_reg(CSR_FALL_STEP, CSR_DATA_W'(step));
      stage_reg(CSR_COLUMN_HEIGHT, with_noise(height, 16'h0FFF));
   endtask

   task automatic send_random_frames(input int budget);
      int count, len, full, i;
      bit noisy;
      count = 0;
      full = active_bars() * active_per();
      if (full == 0) full = $urandom_range(1, 8);
      if (full > 256) full = 256;
      while (count < budget) begin
         noisy = 1'b0;
         case ($urandom_range(9))
            0: begin
               noisy = 1'b1;
               len = $urandom_range(1, 10);
            end
            1:       len = $urandom_range(1, full);
            2:       len = (full > 1) ? full - 1 : 1;
            default: len = full + $urandom_range(0, 3);
         endcase
         for (i = 0; i < len; i++)
            send_bin(random_level(), noisy ? ($urandom_range(7) == 0) : (i == len - 1));
         count += len;
      end
   endtask

   task automatic test_reset_defaults();
      int i;
      // one frame over every bin writes the whole held level store
      for (i = 0; i < NUM_BINS; i++) send_bin(random_level(), i == NUM_BINS - 1);
   endtask

   task automatic test_pass_through();
      program_meter(4, 1, 0, RST_FALL_STEP, 12'hFFF);
      send_bin(16'h0000, 1'b0);
      send_bin(16'h0001, 1'b0);
      send_bin(16'hFFFF, 1'b0);
      send_bin(16'h8000, 1'b1);
   endtask

   task automatic test_group_max();
      program_meter(2, 3, 0, RST_FALL_STEP, 12'hFFF);
      send_bin(16'd100, 1'b0);
      send_bin(16'hFFFF, 1'b0);
      send_bin(16'd7, 1'b0);
      send_bin(16'd0, 1'b0);
      send_bin(16'd0, 1'b0);
      send_bin(16'd1, 1'b1);
   endtask

   task automatic test_gravity_fall();
      program_meter(2, 1, 1, RST_FALL_STEP, RST_COLUMN_HEIGHT);
      send_bin(16'd60000, 1'b0);
      send_bin(16'd100, 1'b1);
      send_bin(16'd10000, 1'b0);
      send_bin(16'd200, 1'b1);
      // full step saturates the fall at zero
      stage_reg(CSR_FALL_STEP, 16'hFFFF);
      commit_regs();
      send_bin(16'hFFFF, 1'b1);
      send_bin(16'd1, 1'b1);
      // zero step holds the peak
      stage_reg(CSR_FALL_STEP, 16'd0);
      commit_regs();
      send_bin(16'd5000, 1'b1);
      send_bin(16'd10, 1'b1);
   endtask

   task automatic test_short_frame();
      program_meter(4, 2, 0, RST_FALL_STEP, RST_COLUMN_HEIGHT);
      // partial group at frame end is dropped
      send_bin(16'd1000, 1'b0);
      send_bin(16'd2000, 1'b0);
      send_bin(16'd3000, 1'b1);
      // bar finished on the frame end bin is the last one
      send_bin(16'd10, 1'b0);
      send_bin(16'd20, 1'b0);
      send_bin(16'd30, 1'b0);
      send_bin(16'd40, 1'b1);
   endtask

   task automatic test_odd_registers();
      program_meter(0, 1, 1, RST_FALL_STEP, RST_COLUMN_HEIGHT);
      send_bin(16'hFFFF, 1'b0);
      send_bin(16'hFFFF, 1'b1);
      program_meter(255, 0, 0, RST_FALL_STEP, 0);
      send_bin(16'hFFFF, 1'b0);
      send_bin(16'd1, 1'b1);
      // unused index leaves everything as it is
      stage_reg(CSR_UNUSED_INDEX, 16'hFFFF);
      commit_regs();
      send_bin(16'h1234, 1'b0);
      send_bin(16'hFFFF, 1'b1);
   endtask

   task automatic test_long_frame();
      int i;
      program_meter(3, 1, 1, $urandom_range(100, 4000), 12'hFFF);
      for (i = 0; i < 20; i++) send_bin(random_level(), i == 19);
      // runs past the last bin and wraps onto held entries
      for (i = 0; i < NUM_BINS + 20; i++) send_bin(random_level(), i == NUM_BINS + 19);
   endtask

   task automatic test_result_hold();
      int i;
      program_meter(128, 1, 1, RST_FALL_STEP, 12'hFFF);
      send_idle_pct = 0;
      hold_req = 300;
      for (i = 0; i < NUM_BINS; i++) send_bin(random_level(), i == NUM_BINS - 1);
   endtask

   task automatic test_random_frames(input int send_pct, input int stall_in, input int budget);
      int start;
      send_idle_pct = send_pct;
      stall_pct = stall_in;
      start = bins_sent;
      while (bins_sent - start < budget) begin
         stage_random_config();
         commit_regs();
         send_random_frames(50);
      end
   endtask

   initial begin
      reset_meter_model();
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_reset_defaults();
      test_pass_through();
      test_group_max();
      test_gravity_fall();
      test_short_frame();
      test_odd_registers();
      test_long_frame();
      test_result_hold();
      test_random_frames(0, 0, 100);
      test_random_frames(63, 0, 100);
      test_random_frames(0, 63, 100);
      test_random_frames(13, 13, 100);
      settle_meter();
      $display("covered %0d bins and %0d register writes, %0d bars checked, %0d errors",
               bins_sent, reg_writes, bars_checked, errors);
      $display("gravity and pass through, group maximum, short and wrapping frames, long result hold");
      if (errors == 0) begin
         $display("spectrum_peak_fall_bar_meter test passed");
      end else begin
         $display("spectrum_peak_fall_bar_meter test failed");
      end
      $finish;
   end

endmodule

`default_nettype wire
